// ----- rtl/core/pvd_pkg.sv -----
package pvd_pkg;

    localparam int WORD_W  = 64;
    localparam int VALUE_W = 61;
    localparam int LEN_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 72;

    localparam logic [LEN_W-1:0] LEN_IDLE = 4'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 4'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 4'd2;
    localparam logic [LEN_W-1:0] LEN_4    = 4'd4;
    localparam logic [LEN_W-1:0] LEN_8    = 4'd8;

    localparam logic [VALUE_W-1:0] OFFSET_1 = 61'd0;
    localparam logic [VALUE_W-1:0] OFFSET_2 = 61'd64;
    localparam logic [VALUE_W-1:0] OFFSET_4 = 61'd8256;
    localparam logic [VALUE_W-1:0] OFFSET_8 = 61'd268443712;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } t_code_word;

endpackage

// ----- rtl/core/pvd_assembler.sv -----
module pvd_assembler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [pvd_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output pvd_pkg::t_code_word        o_code
);

    logic [pvd_pkg::LEN_W-1:0]  r_exp_len, n_exp_len;
    logic [pvd_pkg::LEN_W-1:0]  r_count, n_count;
    logic [pvd_pkg::WORD_W-1:0] r_word, n_word;
    logic                       r_valid, n_valid;
    pvd_pkg::t_code_word        r_code, n_code;

    logic                       w_accept;
    logic [pvd_pkg::BYTE_W-1:0] w_pre;
    logic [pvd_pkg::LEN_W-1:0]  w_pre_len;
    logic [pvd_pkg::LEN_W-1:0]  w_count_inc;
    logic [pvd_pkg::WORD_W-1:0] w_shifted;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_code   = r_code;

    assign w_pre       = i_byte[7] ? ~i_byte : i_byte;
    assign w_count_inc = r_count + 4'd1;
    assign w_shifted   = {r_word[pvd_pkg::WORD_W-pvd_pkg::BYTE_W-1:0], i_byte};

    always_comb begin
        priority if (w_pre[6:4] == 3'b111) begin
            w_pre_len = pvd_pkg::LEN_8;
        end else if (w_pre[6:5] == 2'b11) begin
            w_pre_len = pvd_pkg::LEN_4;
        end else if (w_pre[6]) begin
            w_pre_len = pvd_pkg::LEN_2;
        end else begin
            w_pre_len = pvd_pkg::LEN_1;
        end
    end

    always_comb begin
        n_exp_len = r_exp_len;
        n_count   = r_count;
        n_word    = r_word;
        n_valid   = r_valid && !i_ready;
        n_code    = r_code;
        if (w_accept) begin
            if (r_exp_len == pvd_pkg::LEN_IDLE) begin
                if (w_pre_len == pvd_pkg::LEN_1) begin
                    n_valid     = 1'b1;
                    n_code.word = {{(pvd_pkg::WORD_W-pvd_pkg::BYTE_W){1'b0}}, i_byte};
                    n_code.len  = pvd_pkg::LEN_1;
                end else begin
                    n_exp_len = w_pre_len;
                    n_count   = 4'd1;
                    n_word    = {{(pvd_pkg::WORD_W-pvd_pkg::BYTE_W){1'b0}}, i_byte};
                end
            end else if (w_count_inc >= r_exp_len) begin
                n_valid     = 1'b1;
                n_code.word = w_shifted;
                n_code.len  = r_exp_len;
                n_exp_len   = pvd_pkg::LEN_IDLE;
                n_count     = 4'd0;
                n_word      = '0;
            end else begin
                n_count = w_count_inc;
                n_word  = w_shifted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= pvd_pkg::LEN_IDLE;
            r_count   <= 4'd0;
            r_word    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_exp_len <= n_exp_len;
            r_count   <= n_count;
            r_word    <= n_word;
            r_valid   <= n_valid;
        end
        r_code <= n_code;
    end

endmodule

// ----- rtl/core/pvd_decoder.sv -----
module pvd_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  pvd_pkg::t_code_word         i_code,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pvd_pkg::VALUE_W-1:0] o_value,
    output logic [pvd_pkg::LEN_W-1:0]   o_len
);

    logic                        r_valid, n_valid;
    logic [pvd_pkg::VALUE_W-1:0] r_value, n_value;
    logic [pvd_pkg::LEN_W-1:0]   r_len, n_len;

    logic [pvd_pkg::VALUE_W-1:0] w_payload;
    logic [pvd_pkg::VALUE_W-1:0] w_fill;
    logic [pvd_pkg::VALUE_W-1:0] w_offset;
    logic                        w_neg;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_len   = r_len;

    always_comb begin
        unique case (i_code.len)
            pvd_pkg::LEN_1: begin
                w_payload = {55'd0, i_code.word[5:0]};
                w_fill    = {{55{1'b1}}, 6'd0};
                w_offset  = pvd_pkg::OFFSET_1;
                w_neg     = i_code.word[7];
            end
            pvd_pkg::LEN_2: begin
                w_payload = {48'd0, i_code.word[12:0]};
                w_fill    = {{48{1'b1}}, 13'd0};
                w_offset  = pvd_pkg::OFFSET_2;
                w_neg     = i_code.word[15];
            end
            pvd_pkg::LEN_4: begin
                w_payload = {33'd0, i_code.word[27:0]};
                w_fill    = {{33{1'b1}}, 28'd0};
                w_offset  = pvd_pkg::OFFSET_4;
                w_neg     = i_code.word[31];
            end
            default: begin
                w_payload = {2'd0, i_code.word[58:0]};
                w_fill    = {2'b11, 59'd0};
                w_offset  = pvd_pkg::OFFSET_8;
                w_neg     = i_code.word[63];
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid && !i_ready;
        n_value = r_value;
        n_len   = r_len;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
            n_len   = i_code.len;
            n_value = w_neg ? ((w_payload | w_fill) - w_offset) : (w_payload + w_offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_len   <= n_len;
    end

endmodule

// ----- rtl/core/prefix_varint_stream_decoder_core.sv -----
// A word's result is registered first in the assembler's code register, then in the decoder's output register.
// Throughput: one byte per cycle while the output is not stalled; the assembler and decoder stages each hold one word.
// A word of N bytes takes N input transactions and yields one output transaction.
// Reset: synchronous, active low; clears the word state and both stage valid flags.
module prefix_varint_stream_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [pvd_pkg::TDATA_IN_W-1:0]      i_s_tdata,  // [7:0] data_byte
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [pvd_pkg::TDATA_OUT_W-1:0]     o_m_tdata   // [60:0] decoded_value,
                                                            // [64:61] code_length, [71:65] zero
);

    logic                        w_code_valid;
    logic                        w_code_ready;
    pvd_pkg::t_code_word         w_code;
    logic [pvd_pkg::VALUE_W-1:0] w_value;
    logic [pvd_pkg::LEN_W-1:0]   w_len;

    pvd_assembler u_pvd_assembler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata[7:0]),
        .o_valid (w_code_valid),
        .i_ready (w_code_ready),
        .o_code  (w_code)
    );

    pvd_decoder u_pvd_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_code_valid),
        .o_ready (w_code_ready),
        .i_code  (w_code),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_value (w_value),
        .o_len   (w_len)
    );

    assign o_m_tdata = {7'd0, w_len, w_value};

endmodule

// ----- rtl/core/pvd_checker.sv -----
module pvd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [pvd_pkg::TDATA_OUT_W-1:0] o_m_tdata
);

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("output data changed while stalled");

    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[64:61] == pvd_pkg::LEN_1 || o_m_tdata[64:61] == pvd_pkg::LEN_2
            || o_m_tdata[64:61] == pvd_pkg::LEN_4 || o_m_tdata[64:61] == pvd_pkg::LEN_8))
        else $error("illegal code length");

    a_short_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[64:61] == pvd_pkg::LEN_1
            |-> (o_m_tdata[60:6] == '0 || o_m_tdata[60:6] == '1))
        else $error("one-byte value out of range");

endmodule

bind prefix_varint_stream_decoder_core pvd_checker u_pvd_checker (.*);

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 200;
    localparam logic [7:0] STALL_PATTERN = 8'b1011_0010;

    typedef struct packed {
        logic signed [pvd_pkg::VALUE_W-1:0] value;
        logic [pvd_pkg::LEN_W-1:0]          n_bytes;
    } t_decoded;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [pvd_pkg::TDATA_IN_W-1:0]  i_s_tdata;   // [7:0] data_byte
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [pvd_pkg::TDATA_OUT_W-1:0] o_m_tdata;   // [60:0] decoded_value, [64:61] code_length,
                                                  // [71:65] zero

    t_decoded       decoded_q[$];
    t_decoded       oldest;
    int             err_count  = 0;
    int             bytes_sent = 0;
    int             burst_left = 0;
    bit             gaps_on    = 0;
    bit             hold_req   = 0;
    int             stall_mode = 0;
    int unsigned    rx_tick    = 0;

    logic [pvd_pkg::LEN_W-1:0]  word_len   = pvd_pkg::LEN_IDLE;
    logic [pvd_pkg::LEN_W-1:0]  bytes_seen = '0;
    logic [pvd_pkg::WORD_W-1:0] word_acc   = '0;

    prefix_varint_stream_decoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [pvd_pkg::LEN_W-1:0] prefix_length(logic [7:0] b);
        logic [7:0] p;
        p = b[7] ? ~b : b;
        if (p[6:4] == 3'b111) return pvd_pkg::LEN_8;
        if (p[6:5] == 2'b11) return pvd_pkg::LEN_4;
        if (p[6]) return pvd_pkg::LEN_2;
        return pvd_pkg::LEN_1;
    endfunction

    function automatic logic [pvd_pkg::VALUE_W-1:0] word_value(logic [pvd_pkg::WORD_W-1:0] w,
                                                               logic [pvd_pkg::LEN_W-1:0] n);
        logic [pvd_pkg::WORD_W-1:0] mask;
        logic [pvd_pkg::WORD_W-1:0] ofs;
        logic [pvd_pkg::WORD_W-1:0] sum;
        logic                       neg;
        case (n)
            pvd_pkg::LEN_1: begin
                mask = 64'h3F;
                ofs  = {3'b0, pvd_pkg::OFFSET_1};
                neg  = w[7];
            end
            pvd_pkg::LEN_2: begin
                mask = 64'h1FFF;
                ofs  = {3'b0, pvd_pkg::OFFSET_2};
                neg  = w[15];
            end
            pvd_pkg::LEN_4: begin
                mask = 64'h0FFF_FFFF;
                ofs  = {3'b0, pvd_pkg::OFFSET_4};
                neg  = w[31];
            end
            default: begin
                mask = 64'h07FF_FFFF_FFFF_FFFF;
                ofs  = {3'b0, pvd_pkg::OFFSET_8};
                neg  = w[63];
            end
        endcase
        if (neg) sum = ((w & mask) | ~mask) - ofs;
        else     sum = (w & mask) + ofs;
        return sum[pvd_pkg::VALUE_W-1:0];
    endfunction

    function automatic void track_byte(logic [7:0] b);
        logic [pvd_pkg::LEN_W-1:0] n;
        t_decoded                  d;
        if (word_len == pvd_pkg::LEN_IDLE) begin
            n = prefix_length(b);
            if (n == pvd_pkg::LEN_1) begin
                d.value   = word_value({56'd0, b}, pvd_pkg::LEN_1);
                d.n_bytes = pvd_pkg::LEN_1;
                decoded_q.push_back(d);
            end else begin
                word_len   = n;
                bytes_seen = 4'd1;
                word_acc   = {56'd0, b};
            end
        end else begin
            word_acc   = {word_acc[55:0], b};
            bytes_seen = bytes_seen + 4'd1;
            if (bytes_seen >= word_len) begin
                d.value   = word_value(word_acc, word_len);
                d.n_bytes = word_len;
                decoded_q.push_back(d);
                word_len   = pvd_pkg::LEN_IDLE;
                bytes_seen = '0;
                word_acc   = '0;
            end
        end
    endfunction

    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 5);
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        track_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_code_word();
        logic [7:0] pos;
        int         n;
        case ($urandom_range(0, 3))
            0: begin n = 1; pos = 8'($urandom_range(8'h00, 8'h3F)); end
            1: begin n = 2; pos = 8'($urandom_range(8'h40, 8'h5F)); end
            2: begin n = 4; pos = 8'($urandom_range(8'h60, 8'h6F)); end
            default: begin n = 8; pos = 8'($urandom_range(8'h70, 8'h7F)); end
        endcase
        push_byte($urandom_range(0, 1) ? ~pos : pos);
        for (int i = 1; i < n; i++) push_byte(payload_byte());
    endtask

    task automatic send_mixed(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
            end else begin
                send_code_word();
            end
        end
    endtask

    task automatic wait_for_all_results();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [7:0] seq [28] = '{
            8'h00, 8'hFF, 8'h3F, 8'hC0,
            8'h5F, 8'hFF, 8'hA0, 8'h00,
            8'h90, 8'h00, 8'h00, 8'h00,
            8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
        };
        gaps_on    = 0;
        stall_mode = 0;
        foreach (seq[i]) push_byte(seq[i]);
        wait_for_all_results();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            gaps_on    = (ph != 0);
            stall_mode = ph;
            send_mixed(180);
        end
        wait_for_all_results();
    endtask

    task automatic test_output_hold();
        gaps_on    = 0;
        stall_mode = 0;
        hold_req   = 1;
        send_mixed(60);
        wait_for_all_results();
    endtask

    task automatic test_sender_pause();
        gaps_on    = 1;
        stall_mode = 1;
        send_mixed(40);
        wait_for_all_results();
        stall_mode = 2;
        send_mixed(40);
        wait_for_all_results();
    endtask

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else begin
                rx_tick++;
                case (stall_mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= ($urandom_range(0, 3) != 0);
                    2:       i_m_tready <= STALL_PATTERN[rx_tick[2:0]];
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (decoded_q.size() == 0) begin
                $error("result with nothing expected: tdata=%h", o_m_tdata);
                err_count++;
            end else begin
                oldest = decoded_q.pop_front();
                if (o_m_tdata[60:0] !== oldest.value) begin
                    $error("decoded_value: expected %0d, actual %0d",
                           oldest.value, $signed(o_m_tdata[60:0]));
                    err_count++;
                end
                if (o_m_tdata[64:61] !== oldest.n_bytes) begin
                    $error("code_length: expected %0d, actual %0d",
                           oldest.n_bytes, o_m_tdata[64:61]);
                    err_count++;
                end
                if (o_m_tdata[71:65] !== 7'd0) begin
                    $error("tdata padding: expected 0, actual %h", o_m_tdata[71:65]);
                    err_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic();
        test_output_hold();
        test_sender_pause();

        wait_for_all_results();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pvd_pkg.sv
rtl/core/pvd_assembler.sv
rtl/core/pvd_decoder.sv
rtl/core/prefix_varint_stream_decoder_core.sv
rtl/core/pvd_checker.sv
dv/tb_top.sv
